### src/rgb_quad_to_yuv420_assert.svh
// ---------------------------------------------------------------------------
// rgb_quad_to_yuv420 assertion macros
// Shorthand for the clocked, reset-gated checks used in the converter.
// ---------------------------------------------------------------------------
`ifndef RGB_QUAD_TO_YUV420_ASSERT_SVH
`define RGB_QUAD_TO_YUV420_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define RQY_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset
`define RQY_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rqyuv_pkg.sv
// ---------------------------------------------------------------------------
// rqyuv_pkg
// Types, fixed-point coefficients and helpers for the 2x2 RGB to YUV 4:2:0
// converter.
// ---------------------------------------------------------------------------
package rqyuv_pkg;

    // Fixed-point format of all ratios
    localparam int SHIFT_Q    = 24;
    localparam int COEF_W     = 24;
    localparam int NUM_STAGES = 6;

    // Chroma quotient: the numerator is pre-shifted right by this many bits,
    // then divided by the plain divisor through a reciprocal multiply
    localparam int DIV_DROP    = 16;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 12;
    localparam int DIV_W       = 10;

    // Channel layout of the 32-bit pixel words
    typedef enum logic {
        ORDER_BGRA = 1'b0,
        ORDER_ARGB = 1'b1
    } chan_order_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Chroma channel lanes
    localparam int CH_U = 0;
    localparam int CH_V = 1;

    // Luma coefficients, Q24, rounded to nearest
    localparam logic [63:0] LUMA_KG_FULL =
        ((64'd2560 << SHIFT_Q) + 64'd2536) / 64'd5072;
    localparam logic [63:0] LUMA_KB_FULL =
        (((64'd1934 * 64'd2560) << SHIFT_Q) + 64'd25360000) / 64'd50720000;
    localparam logic [63:0] LUMA_KR_FULL =
        (((64'd509 * 64'd2560) << SHIFT_Q) + 64'd2536000) / 64'd5072000;

    // Chroma luma-estimate coefficients, Q24, rounded to nearest
    localparam logic [63:0] CHR_CG_FULL =
        ((64'd2980 << SHIFT_Q) + 64'd2536) / 64'd5072;
    localparam logic [63:0] CHR_CB_FULL =
        (((64'd1934 * 64'd2980) << SHIFT_Q) + 64'd25360000) / 64'd50720000;
    localparam logic [63:0] CHR_CR_FULL =
        (((64'd509 * 64'd2980) << SHIFT_Q) + 64'd2536000) / 64'd5072000;

    localparam logic [COEF_W-1:0] LUMA_KG = LUMA_KG_FULL[COEF_W-1:0];
    localparam logic [COEF_W-1:0] LUMA_KB = LUMA_KB_FULL[COEF_W-1:0];
    localparam logic [COEF_W-1:0] LUMA_KR = LUMA_KR_FULL[COEF_W-1:0];
    localparam logic [COEF_W-1:0] CHR_CG  = CHR_CG_FULL[COEF_W-1:0];
    localparam logic [COEF_W-1:0] CHR_CB  = CHR_CB_FULL[COEF_W-1:0];
    localparam logic [COEF_W-1:0] CHR_CR  = CHR_CR_FULL[COEF_W-1:0];

    // Divisors and their truncated reciprocals, U lane first
    localparam logic [DIV_W-1:0] CHR_DIV [2] = '{10'd517, 10'd409};
    localparam logic [63:0] U_RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd517;
    localparam logic [63:0] V_RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'd409;
    localparam logic [RECIP_W-1:0] CHR_RECIP [2] =
        '{U_RECIP_FULL[RECIP_W-1:0], V_RECIP_FULL[RECIP_W-1:0]};

    // Pick red, green and blue out of one pixel word
    function automatic rgb_t unpack_pixel(input logic [31:0] w, input chan_order_t ord);
        rgb_t px;
        case (ord)
            ORDER_ARGB:
            begin
                px.r = w[15:8];
                px.g = w[23:16];
                px.b = w[31:24];
            end
            default:
            begin
                px.r = w[23:16];
                px.g = w[15:8];
                px.b = w[7:0];
            end
        endcase
        return px;
    endfunction

    // Saturate a signed value to one byte
    function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 12'sd0)
        begin
            res = 8'd0;
        end
        else if (v > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

### src/rgb_quad_to_yuv420.sv
// ---------------------------------------------------------------------------
// rgb_quad_to_yuv420
// Converts one 2x2 block of 32-bit RGB pixels into four luma bytes and one
// shared U/V pair (YUV 4:2:0) in a six-stage pipeline.
// ---------------------------------------------------------------------------
// The converter takes one 2x2 pixel block per clock cycle while the output
// side does not stall and returns six bytes for each block. The six register
// stages (unpack, products and averages, luma sum and chroma products, chroma
// numerators, reciprocal multiply, quotient correction and clamp) each have
// their own logic, so nothing is shared between blocks in flight. A stalled
// output freezes only the occupied stages: empty stages keep filling, and
// s_tready stays high while any stage is free. channel_order must be written
// only while the pipeline is empty; the alpha byte of every pixel is ignored.
module rgb_quad_to_yuv420 (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write: bit 0 is channel_order
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_data,
    // Pixel block input
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] pixel_top_left, [63:32] pixel_top_right,
    // [95:64] pixel_bottom_left, [127:96] pixel_bottom_right
    input  logic [127:0] s_tdata,
    // YUV output
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] luma_top_left, [15:8] luma_top_right, [23:16] luma_bottom_left,
    // [31:24] luma_bottom_right, [39:32] chroma_blue, [47:40] chroma_red
    output logic [47:0]  m_tdata
);

`include "rgb_quad_to_yuv420_assert.svh"

    localparam int NS     = rqyuv_pkg::NUM_STAGES;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 34;
    localparam int NUM_W  = 35;
    localparam int X_W    = NUM_W - 1 - rqyuv_pkg::DIV_DROP;
    localparam int RP_W   = X_W + rqyuv_pkg::RECIP_W;
    localparam int Q_W    = RP_W - rqyuv_pkg::RECIP_SHIFT;
    localparam int QD_W   = Q_W + rqyuv_pkg::DIV_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    rqyuv_pkg::chan_order_t channel_order_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_order_reg <= rqyuv_pkg::ORDER_BGRA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            channel_order_reg <= rqyuv_pkg::chan_order_t'(cfg_data[0]);
        end
    end

    // ------------------------------------------------------------------
    // Stage enables and valid bits
    // ------------------------------------------------------------------
    logic [NS:1] en;
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    always_comb
    begin
        vld_next[1] = en[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= NS; k++)
        begin
            vld_next[k] = en[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = vld_reg[NS];

    // ------------------------------------------------------------------
    // Stage 1: unpack channels
    // ------------------------------------------------------------------
    rqyuv_pkg::rgb_t s1_pix_next [4];
    rqyuv_pkg::rgb_t s1_pix_reg  [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s1_pix_next[i] = rqyuv_pkg::unpack_pixel(s_tdata[32*i +: 32], channel_order_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_pix_reg <= s1_pix_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: luma products per pixel, channel averages for chroma
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] s2_pg_next [4];
    logic [PROD_W-1:0] s2_pb_next [4];
    logic [PROD_W-1:0] s2_pr_next [4];
    logic [PROD_W-1:0] s2_pg_reg  [4];
    logic [PROD_W-1:0] s2_pb_reg  [4];
    logic [PROD_W-1:0] s2_pr_reg  [4];
    rqyuv_pkg::rgb_t   s2_avg_next;
    rqyuv_pkg::rgb_t   s2_avg_reg;
    logic [9:0]        sum_r;
    logic [9:0]        sum_g;
    logic [9:0]        sum_b;

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 4; i++)
        begin
            s2_pg_next[i] = PROD_W'(s1_pix_reg[i].g) * PROD_W'(rqyuv_pkg::LUMA_KG);
            s2_pb_next[i] = PROD_W'(s1_pix_reg[i].b) * PROD_W'(rqyuv_pkg::LUMA_KB);
            s2_pr_next[i] = PROD_W'(s1_pix_reg[i].r) * PROD_W'(rqyuv_pkg::LUMA_KR);
            sum_r = sum_r + 10'(s1_pix_reg[i].r);
            sum_g = sum_g + 10'(s1_pix_reg[i].g);
            sum_b = sum_b + 10'(s1_pix_reg[i].b);
        end
        // Truncated average: drop the two low bits of the four-pixel sum
        s2_avg_next.r = sum_r[9:2];
        s2_avg_next.g = sum_g[9:2];
        s2_avg_next.b = sum_b[9:2];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_pg_reg  <= s2_pg_next;
            s2_pb_reg  <= s2_pb_next;
            s2_pr_reg  <= s2_pr_next;
            s2_avg_reg <= s2_avg_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: finish luma, chroma luma-estimate products
    // ------------------------------------------------------------------
    logic [7:0]        s3_luma_next [4];
    logic [7:0]        s3_luma_reg  [4];
    logic [PROD_W-1:0] s3_cg_next;
    logic [PROD_W-1:0] s3_cb_next;
    logic [PROD_W-1:0] s3_cr_next;
    logic [PROD_W-1:0] s3_cg_reg;
    logic [PROD_W-1:0] s3_cb_reg;
    logic [PROD_W-1:0] s3_cr_reg;
    logic [7:0]        s3_avg_b_reg;
    logic [7:0]        s3_avg_r_reg;
    logic [ACC_W-1:0]  luma_acc [4];
    logic [10:0]       luma_off [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            luma_acc[i] = ACC_W'(s2_pg_reg[i]) + ACC_W'(s2_pb_reg[i]) + ACC_W'(s2_pr_reg[i]);
            luma_off[i] = 11'(luma_acc[i][ACC_W-1:rqyuv_pkg::SHIFT_Q]) + 11'd16;
            s3_luma_next[i] = rqyuv_pkg::clamp_byte($signed({1'b0, luma_off[i]}));
        end
        s3_cg_next = PROD_W'(s2_avg_reg.g) * PROD_W'(rqyuv_pkg::CHR_CG);
        s3_cb_next = PROD_W'(s2_avg_reg.b) * PROD_W'(rqyuv_pkg::CHR_CB);
        s3_cr_next = PROD_W'(s2_avg_reg.r) * PROD_W'(rqyuv_pkg::CHR_CR);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_luma_reg  <= s3_luma_next;
            s3_cg_reg    <= s3_cg_next;
            s3_cb_reg    <= s3_cb_next;
            s3_cr_reg    <= s3_cr_next;
            s3_avg_b_reg <= s2_avg_reg.b;
            s3_avg_r_reg <= s2_avg_reg.r;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: signed chroma numerators (channel << 24) - luma estimate
    // ------------------------------------------------------------------
    logic [7:0]              s4_luma_reg [4];
    logic signed [NUM_W-1:0] s4_num_next [2];
    logic signed [NUM_W-1:0] s4_num_reg  [2];
    logic [ACC_W-1:0]        chr_est;

    always_comb
    begin
        chr_est = ACC_W'(s3_cg_reg) + ACC_W'(s3_cb_reg) + ACC_W'(s3_cr_reg);
        s4_num_next[rqyuv_pkg::CH_U] = $signed({3'b000, s3_avg_b_reg, 24'd0})
                                     - $signed({1'b0, chr_est});
        s4_num_next[rqyuv_pkg::CH_V] = $signed({3'b000, s3_avg_r_reg, 24'd0})
                                     - $signed({1'b0, chr_est});
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_luma_reg <= s3_luma_reg;
            s4_num_reg  <= s4_num_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: magnitude, drop low bits, reciprocal estimate of quotient
    // ------------------------------------------------------------------
    logic [7:0]       s5_luma_reg [4];
    logic [1:0]       s5_neg_next;
    logic [1:0]       s5_neg_reg;
    logic [X_W-1:0]   s5_x_next  [2];
    logic [X_W-1:0]   s5_x_reg   [2];
    logic [Q_W-1:0]   s5_q0_next [2];
    logic [Q_W-1:0]   s5_q0_reg  [2];
    logic [NUM_W-1:0] num_mag    [2];
    logic [RP_W-1:0]  recip_prod [2];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            s5_neg_next[c] = s4_num_reg[c][NUM_W-1];
            num_mag[c]     = s5_neg_next[c] ? NUM_W'(-s4_num_reg[c]) : NUM_W'(s4_num_reg[c]);
            s5_x_next[c]   = num_mag[c][NUM_W-2:rqyuv_pkg::DIV_DROP];
            recip_prod[c]  = RP_W'(s5_x_next[c]) * RP_W'(rqyuv_pkg::CHR_RECIP[c]);
            s5_q0_next[c]  = recip_prod[c][RP_W-1:rqyuv_pkg::RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_luma_reg <= s4_luma_reg;
            s5_neg_reg  <= s5_neg_next;
            s5_x_reg    <= s5_x_next;
            s5_q0_reg   <= s5_q0_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: correct quotient by one, restore sign, offset and clamp
    // ------------------------------------------------------------------
    logic [7:0]        s6_luma_reg   [4];
    logic [7:0]        s6_chroma_next [2];
    logic [7:0]        s6_chroma_reg  [2];
    logic [QD_W-1:0]   quo_rem [2];
    logic [Q_W-1:0]    quo     [2];
    logic signed [11:0] chr_val [2];

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            quo_rem[c] = QD_W'(s5_x_reg[c])
                       - QD_W'(s5_q0_reg[c]) * QD_W'(rqyuv_pkg::CHR_DIV[c]);
            quo[c] = (quo_rem[c] >= QD_W'(rqyuv_pkg::CHR_DIV[c])) ? s5_q0_reg[c] + 1'b1
                                                                   : s5_q0_reg[c];
            chr_val[c] = s5_neg_reg[c] ? 12'sd128 - $signed(12'(quo[c]))
                                       : 12'sd128 + $signed(12'(quo[c]));
            s6_chroma_next[c] = rqyuv_pkg::clamp_byte(chr_val[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_luma_reg   <= s5_luma_reg;
            s6_chroma_reg <= s6_chroma_next;
        end
    end

    assign m_tdata = {s6_chroma_reg[rqyuv_pkg::CH_V], s6_chroma_reg[rqyuv_pkg::CH_U],
                      s6_luma_reg[3], s6_luma_reg[2], s6_luma_reg[1], s6_luma_reg[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RQY_ASSERT_SAME(a_free_stage_ready, !(&vld_reg), s_tready,
        "input stalled while a pipeline stage is free")
    `RQY_ASSERT_NEXT(a_accept_fills_s1, s_tvalid && s_tready, vld_reg[1],
        "accepted item did not enter the first stage")
    `RQY_ASSERT_SAME(a_u_estimate, vld_reg[5],
        quo_rem[rqyuv_pkg::CH_U] < QD_W'(2 * rqyuv_pkg::CHR_DIV[rqyuv_pkg::CH_U]),
        "U reciprocal estimate off by more than one")
    `RQY_ASSERT_SAME(a_v_estimate, vld_reg[5],
        quo_rem[rqyuv_pkg::CH_V] < QD_W'(2 * rqyuv_pkg::CHR_DIV[rqyuv_pkg::CH_V]),
        "V reciprocal estimate off by more than one")

endmodule

### dv/rgb_quad_to_yuv420_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_quad_to_yuv420_tb
// Self-checking bench for the 2x2 RGB to YUV 4:2:0 block converter. Pixel
// blocks go in on the slave stream and every output item is compared, byte by
// byte, with a bit-exact fixed-point conversion kept here. Both layouts are
// exercised, directed corner blocks come first, random blocks follow, and
// both stream sides idle at random.
// ---------------------------------------------------------------------------
module rgb_quad_to_yuv420_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 14;
    localparam int MAX_REPORTS  = 10;
    localparam int FRAC_BITS    = 24;

    // Q24 ratios, rounded to nearest
    localparam longint unsigned LUMA_G =
        ((64'd2560 << FRAC_BITS) + 64'd2536) / 64'd5072;
    localparam longint unsigned LUMA_B =
        (((64'd1934 * 64'd2560) << FRAC_BITS) + 64'd25360000) / 64'd50720000;
    localparam longint unsigned LUMA_R =
        (((64'd509 * 64'd2560) << FRAC_BITS) + 64'd2536000) / 64'd5072000;
    localparam longint CHROMA_G =
        ((64'sd2980 <<< FRAC_BITS) + 64'sd2536) / 64'sd5072;
    localparam longint CHROMA_B =
        (((64'sd1934 * 64'sd2980) <<< FRAC_BITS) + 64'sd25360000) / 64'sd50720000;
    localparam longint CHROMA_R =
        (((64'sd509 * 64'sd2980) <<< FRAC_BITS) + 64'sd2536000) / 64'sd5072000;
    localparam longint DIV_U = 64'sd517 <<< FRAC_BITS;
    localparam longint DIV_V = 64'sd409 <<< FRAC_BITS;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [0:0]   cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // [31:0] pixel_top_left, [63:32] pixel_top_right,
    // [95:64] pixel_bottom_left, [127:96] pixel_bottom_right
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // [7:0] luma_top_left, [15:8] luma_top_right, [23:16] luma_bottom_left,
    // [31:24] luma_bottom_right, [39:32] chroma_blue, [47:40] chroma_red
    logic [47:0]  m_tdata;

    // Expected YUV items, oldest first
    logic [47:0]  pending_yuv [$];
    rqyuv_pkg::chan_order_t block_order;
    bit           src_calm;
    bit           sink_calm;
    int           cycles;
    int           blocks_sent;
    int           results_seen;
    int           mismatches;
    int           cfg_writes;

    string field_name [6] = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                              "luma_bottom_right", "chroma_blue", "chroma_red"};

    rgb_quad_to_yuv420 DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Saturate to one byte
    function automatic logic [7:0] sat_byte(input longint val);
        if (val < 0)
            return 8'd0;
        else if (val > 255)
            return 8'd255;
        else
            return val[7:0];
    endfunction

    // Bit-exact conversion of one 2x2 block
    function automatic logic [47:0] convert_block(input logic [127:0] blk,
                                                  input rqyuv_pkg::chan_order_t ord);
        logic [31:0]     w;
        logic [7:0]      r, g, b;
        longint unsigned acc;
        longint          sum_r, sum_g, sum_b;
        longint          avg_r, avg_g, avg_b, yc;
        logic [47:0]     res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        res   = '0;
        for (int i = 0; i < 4; i++)
        begin
            w = blk[32*i +: 32];
            if (ord == rqyuv_pkg::ORDER_ARGB)
            begin
                r = w[15:8];
                g = w[23:16];
                b = w[31:24];
            end
            else
            begin
                r = w[23:16];
                g = w[15:8];
                b = w[7:0];
            end
            sum_r += r;
            sum_g += g;
            sum_b += b;
            acc = longint'(g) * LUMA_G + longint'(b) * LUMA_B + longint'(r) * LUMA_R;
            res[8*i +: 8] = sat_byte(longint'(acc >> FRAC_BITS) + 16);
        end
        // Average truncates before the scale by 256
        avg_r = (sum_r / 4) * 256;
        avg_g = (sum_g / 4) * 256;
        avg_b = (sum_b / 4) * 256;
        yc = avg_g * CHROMA_G + avg_b * CHROMA_B + avg_r * CHROMA_R;
        res[39:32] = sat_byte(((avg_b <<< FRAC_BITS) - yc) / DIV_U + 128);
        res[47:40] = sat_byte(((avg_r <<< FRAC_BITS) - yc) / DIV_V + 128);
        return res;
    endfunction

    // Build one pixel word in the given layout
    function automatic logic [31:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a,
                                               input rqyuv_pkg::chan_order_t ord);
        if (ord == rqyuv_pkg::ORDER_ARGB)
            return {b, g, r, a};
        else
            return {a, r, g, b};
    endfunction

    // Send one block; hold until accepted, then record its expected item
    task automatic send_block(input logic [127:0] blk);
        while (!src_calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= blk;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_yuv.push_back(convert_block(blk, block_order));
        blocks_sent++;
    endtask

    // Drop valid and wait until every expected item has come, then drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_yuv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write channel_order while the pipeline is empty
    task automatic write_order(input rqyuv_pkg::chan_order_t ord);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= ord;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        block_order = ord;
        cfg_writes++;
    endtask

    // Corner blocks in the current layout
    task automatic directed_blocks();
        rqyuv_pkg::chan_order_t o;
        o = block_order;
        send_block('0);
        send_block({4{32'hFFFF_FFFF}});
        send_block({4{pack_pixel(8'hFF, 8'h00, 8'h00, 8'h00, o)}});
        send_block({4{pack_pixel(8'h00, 8'hFF, 8'h00, 8'h00, o)}});
        send_block({4{pack_pixel(8'h00, 8'h00, 8'hFF, 8'h00, o)}});
        send_block({4{pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, o)}});
        // Alpha alone must give black
        send_block({4{pack_pixel(8'h00, 8'h00, 8'h00, 8'hFF, o)}});
        send_block({pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h5A, o),
                    pack_pixel(8'h00, 8'h00, 8'hFF, 8'hA5, o),
                    pack_pixel(8'h00, 8'hFF, 8'h00, 8'h3C, o),
                    pack_pixel(8'hFF, 8'h00, 8'h00, 8'hC3, o)});
        // Channel sums that are not multiples of four truncate
        send_block({pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, o),
                    pack_pixel(8'h01, 8'h02, 8'h03, 8'h00, o),
                    pack_pixel(8'h01, 8'h02, 8'h03, 8'h00, o),
                    pack_pixel(8'h01, 8'h02, 8'h03, 8'h00, o)});
        send_block({pack_pixel(8'hFE, 8'hFD, 8'hFC, 8'h00, o),
                    pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, o),
                    pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, o),
                    pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, o)});
        // Strong negative chroma: green full, blue and red dark
        send_block({4{pack_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, o)}});
    endtask

    // Random block: mostly random words, some extreme bytes, some near-flat
    function automatic logic [127:0] random_block();
        logic [127:0] blk;
        logic [31:0]  base;
        int           kind;
        kind = $urandom_range(9);
        if (kind < 6)
        begin
            blk = {$urandom, $urandom, $urandom, $urandom};
        end
        else if (kind < 8)
        begin
            for (int i = 0; i < 16; i++)
                blk[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        else
        begin
            base = $urandom;
            for (int i = 0; i < 4; i++)
                blk[32*i +: 32] = base ^ ($urandom & 32'h0303_0303);
        end
        return blk;
    endfunction

    task automatic test_reset_layout();
        directed_blocks();
    endtask

    task automatic test_argb_layout();
        write_order(rqyuv_pkg::ORDER_ARGB);
        directed_blocks();
    endtask

    task automatic test_layout_switch();
        write_order(rqyuv_pkg::ORDER_BGRA);
        for (int i = 0; i < 20; i++)
            send_block(random_block());
        write_order(rqyuv_pkg::ORDER_ARGB);
        for (int i = 0; i < 20; i++)
            send_block(random_block());
        write_order(rqyuv_pkg::ORDER_BGRA);
    endtask

    task automatic test_random_stream();
        for (int phase = 0; phase < 4; phase++)
        begin
            // Second phase runs with no idling on either side
            src_calm  = (phase == 1);
            sink_calm = (phase == 1);
            for (int i = 0; i < 140; i++)
            begin
                // Hold off once until the pipeline has emptied
                if (phase == 2 && i == 70)
                    wait_idle();
                send_block(random_block());
            end
            src_calm  = 1'b0;
            sink_calm = 1'b0;
            write_order(phase[0] ? rqyuv_pkg::ORDER_BGRA : rqyuv_pkg::ORDER_ARGB);
        end
    endtask

    // Sink side: random back-pressure and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (pending_yuv.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected item %h at cycle %0d", m_tdata, cycles);
                end
                else
                begin
                    logic [47:0] exp_yuv;
                    exp_yuv = pending_yuv.pop_front();
                    for (int f = 0; f < 6; f++)
                    begin
                        if (m_tdata[8*f +: 8] !== exp_yuv[8*f +: 8])
                        begin
                            mismatches++;
                            if (mismatches <= MAX_REPORTS)
                                $display("item %0d %s: expected %h, got %h",
                                         results_seen, field_name[f],
                                         exp_yuv[8*f +: 8], m_tdata[8*f +: 8]);
                        end
                    end
                end
            end
            m_tready <= sink_calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cycles       = 0;
        blocks_sent  = 0;
        results_seen = 0;
        mismatches   = 0;
        cfg_writes   = 0;
        src_calm     = 1'b0;
        sink_calm    = 1'b0;
        block_order  = rqyuv_pkg::ORDER_BGRA;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_layout();
        test_argb_layout();
        test_layout_switch();
        test_random_stream();
        wait_idle();

        if (pending_yuv.size() != 0)
            mismatches++;
        $display("Sent %0d pixel blocks, checked %0d YUV items, %0d layout writes,",
                 blocks_sent, results_seen, cfg_writes);
        $display("both layouts, corner blocks and random back-pressure; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
